// ===== rtl/held_note_list_defines.svh =====
// Assertion macros shared by the held note list RTL.
`ifndef HELD_NOTE_LIST_DEFINES_SVH
`define HELD_NOTE_LIST_DEFINES_SVH

`ifndef SYNTH
`define HNL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define HNL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HNL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define HNL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/hnl_pkg.sv =====
// Types and constants of the held note list.
package hnl_pkg;

   localparam int MAX_NOTES = 32;
   localparam int CNT_W     = $clog2(MAX_NOTES + 1);
   localparam int IDX_W     = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
   localparam int NOTE_W    = 7;
   localparam int VEL_W     = 7;
   localparam int REQ_W     = 2;
   localparam int MODE_W    = 2;

   typedef enum logic [REQ_W-1:0] {
      REQ_NOTE  = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_FLUSH = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      CMD_ON    = 2'd0,
      CMD_OFF   = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_FLUSH = 2'd3
   } cmd_kind_type;

   typedef enum logic [MODE_W-1:0] {
      ORD_NEWEST = 2'd0,
      ORD_HIGH   = 2'd1,
      ORD_LOW    = 2'd2
   } order_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } eng_state_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [NOTE_W-1:0]   note;
      order_type           order;
   } cmd_type;

   typedef struct packed {
      logic [NOTE_W-1:0]   held_note;
      logic                last;
      logic                empty_res;
      logic                overflow;
   } rsp_type;

endpackage

// ===== rtl/hnl_front.sv =====
// Front end: takes request items, classifies them and queues commands.
`include "held_note_list_defines.svh"

module hnl_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [hnl_pkg::REQ_W-1:0]   req_type,
   input  logic [hnl_pkg::NOTE_W-1:0]  req_note,
   input  logic [hnl_pkg::VEL_W-1:0]   req_velocity,
   input  logic                        csr_we,
   input  logic [hnl_pkg::MODE_W-1:0]  csr_order_mode,
   output logic                        cmd_valid,
   output hnl_pkg::cmd_type            cmd,
   input  logic                        cmd_pop
);
   import hnl_pkg::*;

   logic [MODE_W-1:0] mode_ff, mode_in;
   cmd_type           q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   cmd_type           new_cmd;
   logic              keep;
   logic              enq;
   logic              deq;

   always_comb begin
      keep          = 1'b1;
      new_cmd.note  = req_note;
      new_cmd.order = (&mode_ff) ? ORD_LOW : order_type'(mode_ff);
      unique case (req_code_type'(req_type))
         REQ_NOTE:  new_cmd.kind = (req_velocity != '0) ? CMD_ON : CMD_OFF;
         REQ_CLEAR: new_cmd.kind = CMD_CLEAR;
         REQ_FLUSH: new_cmd.kind = CMD_FLUSH;
         default: begin
            new_cmd.kind = CMD_CLEAR;
            keep         = 1'b0;
         end
      endcase
   end

   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign enq       = req_push && !req_full && keep;
   assign deq       = cmd_pop && cmd_valid;

   always_comb begin
      mode_in   = csr_we ? csr_order_mode : mode_ff;
      wr_ptr_in = enq ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = deq ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, enq} - {1'b0, deq};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         mode_ff   <= mode_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   `HNL_ASSERT_IMP(a_cmdq_no_overfill, clock, reset, enq, cnt_ff != 2'd2, "command queue overfilled")

endmodule

// ===== rtl/hnl_engine.sv =====
// Back end: list engine over a row of note cells, plus the result queue.
`include "held_note_list_defines.svh"

module hnl_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  hnl_pkg::cmd_type  cmd,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output hnl_pkg::rsp_type  rsp_item
);
   import hnl_pkg::*;

   eng_state_type     state_ff, state_in;
   logic [NOTE_W-1:0] cell_ff [MAX_NOTES];
   logic [NOTE_W-1:0] cell_in [MAX_NOTES];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  nnew_ff, nnew_in;
   logic              ins_done_ff, ins_done_in;
   logic              ovf_ff, ovf_in;
   logic              hold_v_ff, hold_v_in;
   logic [NOTE_W-1:0] hold_ff, hold_in;
   cmd_kind_type      kind_ff, kind_in;
   logic [NOTE_W-1:0] note_ff, note_in;
   order_type         order_ff, order_in;

   rsp_type           oq_ff [2];
   logic              owr_ff, owr_in;
   logic              ord_ff, ord_in;
   logic [1:0]        ocnt_ff, ocnt_in;

   logic [NOTE_W-1:0] head;
   logic              space;
   logic              at_end;
   logic              first;
   logic              beats0;
   logic              cond_later;
   logic              ins_want;
   logic              is_drop;
   logic              store_full;
   logic              do_shift;
   logic              do_wr;
   logic [NOTE_W-1:0] wval;
   logic [CNT_W-1:0]  wsum;
   logic [IDX_W-1:0]  widx;
   logic              push;
   rsp_type           item;
   logic              opop;

   assign head       = cell_ff[0];
   assign space      = (ocnt_ff != 2'd2);
   assign at_end     = (rem_ff == '0);
   assign first      = (rem_ff == count_ff);
   assign store_full = (count_ff == CNT_W'(MAX_NOTES));
   assign beats0     = (order_ff == ORD_HIGH) ? (note_ff > head) : (note_ff < head);
   assign cond_later = (order_ff == ORD_HIGH) ? (head <= note_ff) : (head >= note_ff);
   assign ins_want   = !ins_done_ff &&
                       (at_end || order_ff == ORD_NEWEST || (first ? beats0 : cond_later));
   assign is_drop    = !ins_want && kind_ff == CMD_OFF && head == note_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && (cmd.kind == CMD_ON || cmd.kind == CMD_OFF)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (at_end && ins_done_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (space) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop     = 1'b0;
      do_shift    = 1'b0;
      do_wr       = 1'b0;
      wval        = head;
      push        = 1'b0;
      item        = '0;
      count_in    = count_ff;
      rem_in      = rem_ff;
      nnew_in     = nnew_ff;
      ins_done_in = ins_done_ff;
      ovf_in      = ovf_ff;
      hold_v_in   = hold_v_ff;
      hold_in     = hold_ff;
      kind_in     = kind_ff;
      note_in     = note_ff;
      order_in    = order_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  CMD_ON, CMD_OFF: begin
                     cmd_pop     = 1'b1;
                     kind_in     = cmd.kind;
                     note_in     = cmd.note;
                     order_in    = cmd.order;
                     rem_in      = count_ff;
                     nnew_in     = '0;
                     hold_v_in   = 1'b0;
                     ins_done_in = (cmd.kind == CMD_OFF) || store_full;
                     ovf_in      = (cmd.kind == CMD_ON) && store_full;
                  end
                  CMD_CLEAR: begin
                     cmd_pop  = 1'b1;
                     count_in = '0;
                  end
                  default: begin
                     if (space) begin
                        cmd_pop        = 1'b1;
                        count_in       = '0;
                        push           = 1'b1;
                        item.last      = 1'b1;
                        item.empty_res = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!(at_end && ins_done_ff)) begin
               if (ins_want) begin
                  if (!hold_v_ff || space) begin
                     do_wr          = 1'b1;
                     wval           = note_ff;
                     ins_done_in    = 1'b1;
                     nnew_in        = nnew_ff + 1'b1;
                     push           = hold_v_ff;
                     item.held_note = hold_ff;
                     item.overflow  = ovf_ff;
                     hold_in        = note_ff;
                     hold_v_in      = 1'b1;
                  end
               end else if (is_drop) begin
                  do_shift = 1'b1;
                  rem_in   = rem_ff - 1'b1;
               end else if (!hold_v_ff || space) begin
                  do_shift       = 1'b1;
                  do_wr          = 1'b1;
                  wval           = head;
                  rem_in         = rem_ff - 1'b1;
                  nnew_in        = nnew_ff + 1'b1;
                  push           = hold_v_ff;
                  item.held_note = hold_ff;
                  item.overflow  = ovf_ff;
                  hold_in        = head;
                  hold_v_in      = 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (space) begin
               push           = 1'b1;
               item.held_note = hold_v_ff ? hold_ff : '0;
               item.last      = 1'b1;
               item.empty_res = !hold_v_ff;
               item.overflow  = ovf_ff;
               count_in       = nnew_ff;
            end
         end
         default: ;
      endcase
   end

   // old entries sit at the bottom, the rebuilt list follows them
   assign wsum = rem_ff + nnew_ff - {{(CNT_W-1){1'b0}}, do_shift};
   assign widx = wsum[IDX_W-1:0];

   for (genvar i = 0; i < MAX_NOTES; i++) begin : g_cell
      if (i < MAX_NOTES - 1) begin : g_mid
         always_comb begin
            cell_in[i] = do_shift ? cell_ff[i+1] : cell_ff[i];
            if (do_wr && widx == IDX_W'(i)) begin
               cell_in[i] = wval;
            end
         end
      end else begin : g_top
         always_comb begin
            cell_in[i] = cell_ff[i];
            if (do_wr && widx == IDX_W'(i)) begin
               cell_in[i] = wval;
            end
         end
      end
      always_ff @(posedge clock) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   assign rsp_empty = (ocnt_ff == 2'd0);
   assign rsp_item  = oq_ff[ord_ff];
   assign opop      = rsp_pop && !rsp_empty;

   always_comb begin
      owr_in  = push ? ~owr_ff : owr_ff;
      ord_in  = opop ? ~ord_ff : ord_ff;
      ocnt_in = ocnt_ff + {1'b0, push} - {1'b0, opop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         oq_ff[owr_ff] <= item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         rem_ff      <= '0;
         nnew_ff     <= '0;
         ins_done_ff <= 1'b0;
         ovf_ff      <= 1'b0;
         hold_v_ff   <= 1'b0;
         owr_ff      <= 1'b0;
         ord_ff      <= 1'b0;
         ocnt_ff     <= 2'd0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         rem_ff      <= rem_in;
         nnew_ff     <= nnew_in;
         ins_done_ff <= ins_done_in;
         ovf_ff      <= ovf_in;
         hold_v_ff   <= hold_v_in;
         owr_ff      <= owr_in;
         ord_ff      <= ord_in;
         ocnt_ff     <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff  <= hold_in;
      kind_ff  <= kind_in;
      note_ff  <= note_in;
      order_ff <= order_in;
   end

   `HNL_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_NOTES), "count out of range")
   `HNL_ASSERT_IMP(a_push_room, clock, reset, push, ocnt_ff != 2'd2, "result queue overfilled")
   `HNL_ASSERT_IMP(a_scan_fits, clock, reset, state_ff == ST_SCAN, ({1'b0, rem_ff} + {1'b0, nnew_ff}) <= ({1'b0, count_ff} + 1'b1), "list grew past one insert")
   `HNL_ASSERT_NXT(a_finish_idle, clock, reset, state_ff == ST_FINISH && space, state_ff == ST_IDLE, "finish did not return to idle")

endmodule

// ===== rtl/held_note_list.sv =====
// Top level of the held note list.
// For a note event the engine walks the row of note cells one entry per cycle while the result
// queue has room, rebuilding the list in place (insert or remove) while it sends each entry out,
// then closes with the last-marked result. A dropped insert on a full store walks all 32
// entries. Flush waits for room in the result queue. Two commands queue between the front end
// and the engine, and two results queue at the output; the engine waits while the result
// queue is full.
module held_note_list (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [hnl_pkg::REQ_W-1:0]   req_type,
   input  logic [hnl_pkg::NOTE_W-1:0]  req_note,
   input  logic [hnl_pkg::VEL_W-1:0]   req_velocity,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [hnl_pkg::NOTE_W-1:0]  rsp_held_note,
   output logic                        rsp_last,
   output logic                        rsp_empty_res,
   output logic                        rsp_overflow,
   input  logic                        csr_we,
   input  logic [hnl_pkg::MODE_W-1:0]  csr_order_mode
);
   import hnl_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;
   rsp_type rsp_item;

   hnl_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_type       (req_type),
      .req_note       (req_note),
      .req_velocity   (req_velocity),
      .csr_we         (csr_we),
      .csr_order_mode (csr_order_mode),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   hnl_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   assign rsp_held_note = rsp_item.held_note;
   assign rsp_last      = rsp_item.last;
   assign rsp_empty_res = rsp_item.empty_res;
   assign rsp_overflow  = rsp_item.overflow;

endmodule
